@@ rtl/core/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

   localparam int PAGE_COUNT_DEF = 4096;
   localparam int TOP_ORDER_DEF  = 10;

   localparam int REQ_W    = 2;
   localparam int PAGE_W   = 12;
   localparam int ORDER_W  = 4;
   localparam int COUNT_W  = 13;

   // configuration register indexes
   localparam logic CSR_FIRST_FREE = 1'b0;
   localparam logic CSR_END_PAGE   = 1'b1;

   // request kinds
   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_INIT  = 2'd2
   } req_kind_type;

   // result codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_MEM    = 2'd1,
      STAT_BAD_ARG   = 2'd2,
      STAT_NOT_ALLOC = 2'd3
   } status_type;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [PAGE_W-1:0]  page_index;
      logic [ORDER_W-1:0] block_order;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [PAGE_W-1:0]  block_page;
      logic [COUNT_W-1:0] free_pages;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/core/bpa_ram.sv @@
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/buddy_page_allocator.sv @@
`default_nettype none

// alloc: pop the list head, one split step per order split off; free: check the mark,
//   then per merge level read the buddy mark and walk its free list; an item leaves
//   through the output register once that register is free
// throughput: one item at a time, rate set by the free-list walks in the link memory
// init: a clearing pass over the page marks, then one release per aligned block
// reset: synchronous; clearing pass over the page marks, no item taken

module buddy_page_allocator #(
   parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
   parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bpa_pkg::req_item_type        req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bpa_pkg::rsp_item_type        rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [bpa_pkg::COUNT_W-1:0]  csr_wdata
);

   import bpa_pkg::*;

   // widths: page address, link value (holds the empty marker), order
   localparam int PW = $clog2(PAGE_COUNT);
   localparam int AW = $clog2(PAGE_COUNT + 1);
   localparam int HW = $clog2(TOP_ORDER + 1);
   localparam int XW = (AW > COUNT_W) ? AW : COUNT_W;
   localparam int KW = XW + ORDER_W;
   localparam int MW = 1 + HW;

   localparam logic [AW-1:0]      NO_PAGE        = AW'(PAGE_COUNT);
   localparam logic [COUNT_W-1:0] END_PAGE_RESET = COUNT_W'(4096);

   typedef enum logic [11:0] {
      S_CLEAR       = 12'b0000_0000_0001,
      S_IDLE        = 12'b0000_0000_0010,
      S_ALLOC_POP   = 12'b0000_0000_0100,
      S_ALLOC_SPLIT = 12'b0000_0000_1000,
      S_FREE_CHK    = 12'b0000_0001_0000,
      S_REL         = 12'b0000_0010_0000,
      S_REL_META    = 12'b0000_0100_0000,
      S_WALK        = 12'b0000_1000_0000,
      S_WALK_RD     = 12'b0001_0000_0000,
      S_PUSH        = 12'b0010_0000_0000,
      S_INIT_BLK    = 12'b0100_0000_0000,
      S_DONE        = 12'b1000_0000_0000
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   first_ff, first_in;
   logic [COUNT_W-1:0]  end_ff, end_in;
   logic [AW-1:0]       head_ff [TOP_ORDER+1];
   logic [AW-1:0]       head_in [TOP_ORDER+1];
   logic [AW-1:0]       free_ff, free_in;
   logic [PW-1:0]       clr_ff, clr_in;
   logic                init_mode_ff, init_mode_in;

   // working registers
   rsp_item_type        rsp_ff, rsp_in;
   status_type          status_ff, status_in;
   logic [PW-1:0]       got_ff, got_in;
   logic [PW-1:0]       pg_ff, pg_in;
   logic [HW-1:0]       ord_ff, ord_in;
   logic [HW-1:0]       f_ff, f_in;
   logic [HW-1:0]       idx_ff, idx_in;
   logic [PW-1:0]       buddy_ff, buddy_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [AW-1:0]       prev_ff, prev_in;
   logic [AW-1:0]       steps_ff, steps_in;
   logic [XW-1:0]       init_pg_ff, init_pg_in;

   // memory ports
   logic                meta_we, meta_re;
   logic [PW-1:0]       meta_waddr, meta_raddr;
   logic [MW-1:0]       meta_wdata, meta_rdata;
   logic                link_we, link_re;
   logic [PW-1:0]       link_waddr, link_raddr;
   logic [AW-1:0]       link_wdata, link_rdata;

   // decode helpers
   logic [XW-1:0]       end_x;
   logic [XW-1:0]       eff_end;
   logic                order_bad;
   logic                align_bad;
   logic                range_bad;
   logic [HW-1:0]       req_ord;
   logic                found;
   logic [HW-1:0]       f_sel;
   logic [AW-1:0]       f_head;
   logic [KW-1:0]       init_room;
   logic                init_ok;
   logic [HW-1:0]       init_ord;
   logic [PW-1:0]       buddy_w;
   logic                rsp_load;

   // page marks: in-use bit and order, reset by the clearing pass
   bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   // free-list links, only entries of listed blocks are ever read
   bpa_ram #(.WIDTH(AW), .DEPTH(PAGE_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   // end of range clipped to the page count
   assign end_x   = XW'(end_ff);
   assign eff_end = (end_x > XW'(PAGE_COUNT)) ? XW'(PAGE_COUNT) : end_x;

   // request checks: order for alloc and free, alignment and range for free
   assign order_bad = (req_payload.block_order > ORDER_W'(TOP_ORDER));
   assign align_bad = ((req_payload.page_index &
                        ((PAGE_W'(1) << req_payload.block_order) - PAGE_W'(1))) != '0);
   assign range_bad = (req_payload.page_index < first_ff) ||
                      (XW'(req_payload.page_index) >= eff_end);
   assign req_ord   = HW'(req_payload.block_order);

   // smallest non-empty list at or above the asked order
   always_comb begin
      found  = 1'b0;
      f_sel  = '0;
      f_head = NO_PAGE;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if (HW'(k) >= req_ord && head_ff[k] < NO_PAGE) begin
            found  = 1'b1;
            f_sel  = HW'(k);
            f_head = head_ff[k];
         end
      end
   end

   // largest aligned block that fits at the init cursor
   assign init_room = KW'(eff_end) - KW'(init_pg_ff);

   always_comb begin
      init_ok  = 1'b1;
      init_ord = '0;
      for (int k = 1; k <= TOP_ORDER; k++) begin
         if (init_ok && ((KW'(1) << k) <= init_room) &&
             ((KW'(init_pg_ff) & ((KW'(1) << k) - KW'(1))) == '0)) begin
            init_ord = HW'(k);
         end else begin
            init_ok = 1'b0;
         end
      end
   end

   assign buddy_w = pg_ff ^ (PW'(1) << ord_ff);

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      end_in       = end_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      clr_in       = clr_ff;
      init_mode_in = init_mode_ff;
      status_in    = status_ff;
      got_in       = got_ff;
      pg_in        = pg_ff;
      ord_in       = ord_ff;
      f_in         = f_ff;
      idx_in       = idx_ff;
      buddy_in     = buddy_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      init_pg_in   = init_pg_ff;
      rsp_load     = 1'b0;
      meta_we      = 1'b0;
      meta_waddr   = pg_ff;
      meta_wdata   = '0;
      meta_re      = 1'b0;
      meta_raddr   = pg_ff;
      link_we      = 1'b0;
      link_waddr   = pg_ff;
      link_wdata   = head_ff[ord_ff];
      link_re      = 1'b0;
      link_raddr   = PW'(cur_ff);

      // register writes, taken at any time
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIRST_FREE: first_in = PAGE_W'(csr_wdata);
            CSR_END_PAGE:   end_in   = csr_wdata;
            default:        end_in   = end_ff;
         endcase
      end

      unique case (state_ff)
         // sweep the page marks to zero, one page a cycle
         S_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + PW'(1);
            if (clr_ff == PW'(PAGE_COUNT - 1)) begin
               clr_in   = '0;
               state_in = init_mode_ff ? S_INIT_BLK : S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               status_in = STAT_OK;
               got_in    = '0;
               ord_in    = req_ord;
               unique case (req_payload.req_type)
                  REQ_ALLOC: begin
                     if (order_bad) begin
                        status_in = STAT_BAD_ARG;
                        state_in  = S_DONE;
                     end else if (!found) begin
                        status_in = STAT_NO_MEM;
                        state_in  = S_DONE;
                     end else begin
                        // pop the head, its link comes back next cycle
                        pg_in      = PW'(f_head);
                        f_in       = f_sel;
                        link_re    = 1'b1;
                        link_raddr = PW'(f_head);
                        state_in   = S_ALLOC_POP;
                     end
                  end
                  REQ_FREE: begin
                     if (order_bad || align_bad || range_bad) begin
                        status_in = STAT_BAD_ARG;
                        state_in  = S_DONE;
                     end else begin
                        pg_in      = PW'(req_payload.page_index);
                        meta_re    = 1'b1;
                        meta_raddr = PW'(req_payload.page_index);
                        state_in   = S_FREE_CHK;
                     end
                  end
                  REQ_INIT: begin
                     for (int k = 0; k <= TOP_ORDER; k++) begin
                        head_in[k] = NO_PAGE;
                     end
                     free_in      = '0;
                     init_mode_in = 1'b1;
                     init_pg_in   = XW'(first_ff);
                     state_in     = S_CLEAR;
                  end
                  default: begin
                     status_in = STAT_BAD_ARG;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_ALLOC_POP: begin
            head_in[f_ff] = link_rdata;
            free_in       = free_ff - (AW'(1) << f_ff);
            idx_in        = ord_ff;
            state_in      = S_ALLOC_SPLIT;
         end

         // lists below the popped order are empty, so each upper buddy starts its list
         S_ALLOC_SPLIT: begin
            if (idx_ff < f_ff) begin
               link_we         = 1'b1;
               link_waddr      = pg_ff | (PW'(1) << idx_ff);
               link_wdata      = NO_PAGE;
               head_in[idx_ff] = AW'(pg_ff | (PW'(1) << idx_ff));
               free_in         = free_ff + (AW'(1) << idx_ff);
               idx_in          = idx_ff + HW'(1);
            end else begin
               meta_we    = 1'b1;
               meta_waddr = pg_ff;
               meta_wdata = {1'b1, ord_ff};
               got_in     = pg_ff;
               state_in   = S_DONE;
            end
         end

         S_FREE_CHK: begin
            if (!meta_rdata[MW-1] || meta_rdata[HW-1:0] != ord_ff) begin
               status_in = STAT_NOT_ALLOC;
               state_in  = S_DONE;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = pg_ff;
               meta_wdata = '0;
               state_in   = S_REL;
            end
         end

         // merge step: below the top order, buddy in range, not in use and found on its list
         S_REL: begin
            if (ord_ff < HW'(TOP_ORDER) && XW'(buddy_w) >= XW'(first_ff) &&
                XW'(buddy_w) < eff_end) begin
               buddy_in   = buddy_w;
               meta_re    = 1'b1;
               meta_raddr = buddy_w;
               state_in   = S_REL_META;
            end else begin
               state_in = S_PUSH;
            end
         end

         S_REL_META: begin
            if (meta_rdata[MW-1]) begin
               state_in = S_PUSH;
            end else begin
               cur_in   = head_ff[ord_ff];
               prev_in  = NO_PAGE;
               steps_in = '0;
               state_in = S_WALK;
            end
         end

         // search the list of this order for the buddy
         S_WALK: begin
            if (cur_ff >= NO_PAGE || steps_ff == NO_PAGE) begin
               state_in = S_PUSH;
            end else begin
               link_re    = 1'b1;
               link_raddr = PW'(cur_ff);
               state_in   = S_WALK_RD;
            end
         end

         S_WALK_RD: begin
            if (cur_ff == AW'(buddy_ff)) begin
               if (prev_ff >= NO_PAGE) begin
                  head_in[ord_ff] = link_rdata;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = PW'(prev_ff);
                  link_wdata = link_rdata;
               end
               free_in  = free_ff - (AW'(1) << ord_ff);
               pg_in    = pg_ff & ~(PW'(1) << ord_ff);
               ord_in   = ord_ff + HW'(1);
               state_in = S_REL;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               steps_in = steps_ff + AW'(1);
               state_in = S_WALK;
            end
         end

         S_PUSH: begin
            link_we         = 1'b1;
            link_waddr      = pg_ff;
            link_wdata      = head_ff[ord_ff];
            head_in[ord_ff] = AW'(pg_ff);
            free_in         = free_ff + (AW'(1) << ord_ff);
            state_in        = init_mode_ff ? S_INIT_BLK : S_DONE;
         end

         // next aligned block of the configured range
         S_INIT_BLK: begin
            if (init_pg_ff < eff_end) begin
               pg_in      = PW'(init_pg_ff);
               ord_in     = init_ord;
               init_pg_in = init_pg_ff + (XW'(1) << init_ord);
               state_in   = S_REL;
            end else begin
               init_mode_in = 1'b0;
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.status     = status_ff;
         rsp_in.block_page = PAGE_W'(got_ff);
         rsp_in.free_pages = COUNT_W'(free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
         end_ff       <= END_PAGE_RESET;
         for (int k = 0; k <= TOP_ORDER; k++) begin
            head_ff[k] <= NO_PAGE;
         end
         free_ff      <= '0;
         clr_ff       <= '0;
         init_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         end_ff       <= end_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         clr_ff       <= clr_in;
         init_mode_ff <= init_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      status_ff  <= status_in;
      got_ff     <= got_in;
      pg_ff      <= pg_in;
      ord_ff     <= ord_in;
      f_ff       <= f_in;
      idx_ff     <= idx_in;
      buddy_ff   <= buddy_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      init_pg_ff <= init_pg_in;
   end

   // an accepted item always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted item left the control idle");

   // free page total never exceeds the pool
   assert property (@(posedge clock) disable iff (reset)
      free_ff <= AW'(PAGE_COUNT))
      else $error("free page total above page count");

   // a page is only reported for a successful allocation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STAT_OK || rsp_payload.block_page == '0))
      else $error("block page set on a failed request");

   // a new result is loaded only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a pending item");

endmodule

`default_nettype wire

@@ test/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int NPAGES   = 4096;
   localparam int MAX_ORD  = 10;
   localparam int LIMIT    = 40_000_000;
   localparam int N_PHASES = 7;
   localparam int PER_PHASE = 255;
   localparam logic [1:0] REQ_BAD = 2'd3;

   // allocator state mirror plus the queue of expected responses
   class alloc_scoreboard;
      int unsigned link_mem [NPAGES];
      int unsigned head [MAX_ORD+1];
      int unsigned cnt [MAX_ORD+1];
      bit          in_use [NPAGES];
      int unsigned ord_of [NPAGES];
      int unsigned first_pg;
      int unsigned end_pg;
      rsp_item_type pending [$];
      int errors;

      function void wipe();
         for (int i = 0; i < NPAGES; i++) begin
            link_mem[i] = 0;
            in_use[i] = 0;
            ord_of[i] = 0;
         end
         for (int o = 0; o <= MAX_ORD; o++) begin
            head[o] = NPAGES;
            cnt[o] = 0;
         end
      endfunction

      function new();
         wipe();
         first_pg = 0;
         end_pg = 4096;
         errors = 0;
      endfunction

      function int unsigned top_page();
         return (end_pg > NPAGES) ? NPAGES : end_pg;
      endfunction

      function void push(int unsigned o, int unsigned pg);
         if (pg >= NPAGES) return;
         link_mem[pg] = head[o];
         head[o] = pg;
         cnt[o]++;
      endfunction

      function bit unlink(int unsigned o, int unsigned pg);
         int unsigned prev, cur;
         prev = NPAGES;
         cur = head[o];
         for (int s = 0; s < NPAGES && cur < NPAGES; s++) begin
            if (cur == pg) begin
               if (prev == NPAGES) head[o] = link_mem[cur];
               else link_mem[prev] = link_mem[cur];
               if (cnt[o] > 0) cnt[o]--;
               return 1;
            end
            prev = cur;
            cur = link_mem[cur];
         end
         return 0;
      endfunction

      // drop the in-use mark and coalesce upward while the buddy sits on its list
      function void release_blk(int unsigned pg, int unsigned o);
         int unsigned lim, bud;
         lim = top_page();
         in_use[pg] = 0;
         while (o < MAX_ORD) begin
            bud = pg ^ (1 << o);
            if (bud < first_pg || bud >= lim || in_use[bud]) break;
            if (!unlink(o, bud)) break;
            pg &= ~(1 << o);
            o++;
         end
         push(o, pg);
      endfunction

      function int unsigned free_total();
         int unsigned sum;
         sum = 0;
         for (int o = 0; o <= MAX_ORD; o++) sum += cnt[o] << o;
         return sum;
      endfunction

      function void rebuild();
         int unsigned lim, pg, o;
         lim = top_page();
         pg = first_pg;
         wipe();
         while (pg < lim) begin
            o = 0;
            while (o < MAX_ORD && pg + (2 << o) <= lim && (pg & ((2 << o) - 1)) == 0) o++;
            in_use[pg] = 1;
            ord_of[pg] = o;
            release_blk(pg, o);
            pg += 1 << o;
         end
      endfunction

      function void set_reg(logic idx, logic [12:0] v);
         if (idx == CSR_FIRST_FREE) first_pg = v[11:0];
         else end_pg = v;
      endfunction

      // work out the response to an accepted request and queue it
      function rsp_item_type note_request(req_item_type r);
         rsp_item_type e;
         int unsigned o, pg, f, b;
         o = r.block_order;
         pg = r.page_index;
         e.status = STAT_OK;
         e.block_page = '0;
         case (r.req_type)
            REQ_ALLOC: begin
               if (o > MAX_ORD) e.status = STAT_BAD_ARG;
               else begin
                  f = o;
                  while (f <= MAX_ORD && head[f] >= NPAGES) f++;
                  if (f > MAX_ORD) e.status = STAT_NO_MEM;
                  else begin
                     b = head[f];
                     head[f] = link_mem[b];
                     if (cnt[f] > 0) cnt[f]--;
                     for (int i = o; i < f; i++) begin
                        if ((b ^ (1 << i)) < NPAGES) begin
                           ord_of[b ^ (1 << i)] = i;
                           push(i, b ^ (1 << i));
                        end
                     end
                     in_use[b] = 1;
                     ord_of[b] = o;
                     e.block_page = b[11:0];
                  end
               end
            end
            REQ_FREE: begin
               if (o > MAX_ORD || (pg & ((1 << o) - 1)) != 0 ||
                   pg < first_pg || pg >= top_page())
                  e.status = STAT_BAD_ARG;
               else if (!in_use[pg] || ord_of[pg] != o)
                  e.status = STAT_NOT_ALLOC;
               else
                  release_blk(pg, o);
            end
            REQ_INIT: rebuild();
            default: e.status = STAT_BAD_ARG;
         endcase
         e.free_pages = COUNT_W'(free_total());
         pending.push_back(e);
         return e;
      endfunction

      function void check_response(rsp_item_type a);
         rsp_item_type e;
         if (pending.size() == 0) begin
            if (errors < 10) $display("unexpected response %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status || a.block_page !== e.block_page ||
             a.free_pages !== e.free_pages) begin
            if (errors < 10)
               $display("mismatch: expected st=%0d pg=%0d free=%0d, got st=%0d pg=%0d free=%0d",
                        e.status, e.block_page, e.free_pages,
                        a.status, a.block_page, a.free_pages);
            errors++;
         end
      endfunction
   endclass

   typedef struct {
      int unsigned pg;
      int unsigned ord;
   } held_block_type;

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_item_type req_payload;
   rsp_item_type rsp_payload;
   logic csr_valid, csr_ready, csr_index;
   logic [COUNT_W-1:0] csr_wdata;

   alloc_scoreboard sb = new();
   held_block_type held [$];
   held_block_type last_freed;
   int tx_pct, rx_pct;
   int cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   buddy_page_allocator dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // receiver back-pressure, random per cycle in the stall phases
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   // one request through the handshake; valid stays up if the next item follows at once
   task automatic send(logic [1:0] kind, int unsigned pg, int unsigned o);
      req_item_type r;
      rsp_item_type e;
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      r.req_type = kind;
      r.page_index = pg[11:0];
      r.block_order = o[3:0];
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      e = sb.note_request(r);
      // remember what we now own so later frees hit live blocks
      if (kind == REQ_ALLOC && e.status == STAT_OK) held.push_back('{e.block_page, o});
   endtask

   task automatic free_held(int idx);
      last_freed = held[idx];
      held.delete(idx);
      send(REQ_FREE, last_freed.pg, last_freed.ord);
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [COUNT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45 && held.size() < 60) begin
         // mostly small orders, a few large and a few out of range
         if ($urandom_range(99) < 70) send(REQ_ALLOC, $urandom, $urandom_range(3));
         else if ($urandom_range(99) < 85) send(REQ_ALLOC, $urandom, $urandom_range(MAX_ORD));
         else send(REQ_ALLOC, $urandom, $urandom_range(15));
      end else if (sel < 88 && held.size() != 0) begin
         free_held($urandom_range(held.size() - 1));
      end else if (sel < 92) begin
         send(REQ_FREE, last_freed.pg, last_freed.ord);    // double free
      end else if (sel < 98) begin
         send(REQ_FREE, $urandom, $urandom_range(15));     // noise
      end else if (sel < 99) begin
         send(REQ_BAD, $urandom, $urandom);
      end else begin
         held.delete();
         send(REQ_INIT, $urandom, $urandom);
      end
   endtask

   int unsigned cfg_first [N_PHASES] = '{0, 0, 100, 4095, 0, 37, 2048};
   int unsigned cfg_end [N_PHASES]   = '{4096, 8191, 1000, 4096, 1, 3001, 2048};

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FIRST_FREE;
      csr_wdata = '0;
      tx_pct = 0;
      rx_pct = 0;
      last_freed = '{0, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty lists, bad requests, then a fresh pool
      send(REQ_ALLOC, 0, 0);                 // nothing listed yet
      send(REQ_FREE, 0, 0);                  // never allocated
      send(REQ_BAD, 12'hFFF, 4'hF);
      send(REQ_ALLOC, 0, 11);                // order too large
      send(REQ_INIT, 0, 0);
      send(REQ_ALLOC, 0, MAX_ORD);
      send(REQ_ALLOC, 0, 0);
      send(REQ_ALLOC, 0, 1);
      send(REQ_ALLOC, 0, 15);
      send(REQ_FREE, 12'hFFF, 0);            // not allocated
      send(REQ_FREE, 1, 1);                  // misaligned
      send(REQ_FREE, 0, 12);                 // order too large
      send(REQ_FREE, held[1].pg, held[1].ord + 1);   // wrong order
      free_held(1);
      send(REQ_FREE, last_freed.pg, last_freed.ord);
      free_held(0);
      for (int i = 0; i < 5; i++) send(REQ_ALLOC, 0, MAX_ORD);   // runs dry
      while (held.size() != 0) free_held(held.size() - 1);

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         write_csr(CSR_FIRST_FREE, COUNT_W'(cfg_first[p]));
         write_csr(CSR_END_PAGE, COUNT_W'(cfg_end[p]));
         case (p % 4)
            0: begin tx_pct = 0;  rx_pct = 0;  end
            1: begin tx_pct = 66; rx_pct = 0;  end
            2: begin tx_pct = 0;  rx_pct = 66; end
            default: begin tx_pct = 24; rx_pct = 24; end
         endcase
         held.delete();
         send(REQ_INIT, 0, 0);
         for (int i = 0; i < PER_PHASE; i++) begin
            if (i == PER_PHASE / 2) drain();   // let the pipe empty mid-phase
            random_item();
         end
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
